// ----- src/fpi_pkg.sv -----
// Shared types, codes and constants of the FRU product info area parser.
package fpi_pkg;

    // Default width of the image address counter
    localparam int PositionBitsDefault = 12;

    // Common header layout and checks
    localparam int        HdrOffsetAddr = 4;
    localparam int        HdrPadAddr    = 6;
    localparam int        HdrLastAddr   = 7;
    localparam logic [7:0] FORMAT_VERSION = 8'h01;
    localparam logic [7:0] HDR_PAD_VALUE  = 8'h00;

    // Type/length byte
    localparam logic [7:0] END_MARKER      = 8'hC1;
    localparam logic [3:0] FIXED_FIELDS    = 4'd7;
    localparam logic [3:0] FIELD_INDEX_MAX = 4'd15;

    // Type codes in the top two bits of a type/length byte
    localparam logic [1:0] TYPE_BINARY = 2'd0;
    localparam logic [1:0] TYPE_BCD    = 2'd1;
    localparam logic [1:0] TYPE_SIXBIT = 2'd2;
    localparam logic [1:0] TYPE_TEXT   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_FINAL = 2'd3;

    // Final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HEADER    = 3'd1;
    localparam logic [2:0] ST_NO_AREA   = 3'd2;
    localparam logic [2:0] ST_AREA_VER  = 3'd3;
    localparam logic [2:0] ST_TYPE      = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;
    localparam logic [2:0] ST_CHECKSUM  = 3'd6;
    localparam logic [2:0] ST_TRUNCATED = 3'd7;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_SKIP   = 4'd1,
        PH_LEN    = 4'd2,
        PH_LANG   = 4'd3,
        PH_TL     = 4'd4,
        PH_DATA   = 4'd5,
        PH_PAD    = 4'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_end;
    } fpi_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] field_index;
        logic [7:0] char_value;
        logic       field_last;
        logic [2:0] status;
    } fpi_out_t;

endpackage

// ----- src/fpi_parse_core.sv -----
// Parser state registers and the per-byte next-state and result logic.
module fpi_parse_core
    import fpi_pkg::*;
#(
    parameter int POSITION_BITS = PositionBitsDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  fpi_in_t  step_data,
    output fpi_out_t result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] image_pos_reg, image_pos_next;
    logic [7:0]               area_offset_reg, area_offset_next;
    logic [10:0]              area_length_reg, area_length_next;
    logic [10:0]              area_pos_reg, area_pos_next;
    logic [7:0]               sum_reg, sum_next;
    logic [5:0]               remaining_reg, remaining_next;
    logic [1:0]               field_kind_reg, field_kind_next;
    logic [3:0]               field_number_reg, field_number_next;
    logic                     finished_reg, finished_next;

    logic [7:0]  b;
    logic [7:0]  sum_add;
    logic        past_end;
    logic        area_byte;
    logic [10:0] area_pos_base;
    logic [5:0]  tl_length;
    logic [1:0]  tl_type;
    logic [3:0]  field_number_inc;

    assign b                = step_data.data_byte;
    assign sum_add          = sum_reg + b;
    assign past_end         = ({1'b0, area_pos_reg} + 12'd1) >= {1'b0, area_length_reg};
    assign tl_type          = b[7:6];
    assign tl_length        = b[5:0];
    assign field_number_inc = (field_number_reg < FIELD_INDEX_MAX) ?
                              field_number_reg + 4'd1 : field_number_reg;

    // Decode one image byte: next state and the result it gives
    always_comb
    begin
        phase_next        = phase_reg;
        area_offset_next  = area_offset_reg;
        area_length_next  = area_length_reg;
        sum_next          = sum_reg;
        remaining_next    = remaining_reg;
        field_kind_next   = field_kind_reg;
        field_number_next = field_number_reg;
        finished_next     = finished_reg;
        area_byte         = 1'b0;
        area_pos_base     = area_pos_reg;
        result            = '0;

        if (!finished_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    sum_next = sum_add;
                    if (image_pos_reg == '0 && b != FORMAT_VERSION)
                    begin
                        finished_next = 1'b1;
                        result.kind   = KIND_FINAL;
                        result.status = ST_HEADER;
                    end
                    else
                    begin
                        if (image_pos_reg == POSITION_BITS'(HdrOffsetAddr))
                            area_offset_next = b;
                        if (image_pos_reg == POSITION_BITS'(HdrPadAddr) && b != HDR_PAD_VALUE)
                        begin
                            finished_next = 1'b1;
                            result.kind   = KIND_FINAL;
                            result.status = ST_HEADER;
                        end
                        else if (image_pos_reg == POSITION_BITS'(HdrLastAddr))
                        begin
                            if (sum_add != 8'd0)
                            begin
                                finished_next = 1'b1;
                                result.kind   = KIND_FINAL;
                                result.status = ST_HEADER;
                            end
                            else if (area_offset_reg == 8'd0)
                            begin
                                finished_next = 1'b1;
                                result.kind   = KIND_FINAL;
                                result.status = ST_NO_AREA;
                            end
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (image_pos_reg == POSITION_BITS'({area_offset_reg, 3'b000}))
                    begin
                        if (b != FORMAT_VERSION)
                        begin
                            finished_next = 1'b1;
                            result.kind   = KIND_FINAL;
                            result.status = ST_AREA_VER;
                        end
                        else
                        begin
                            sum_next      = b;
                            area_pos_base = '0;
                            area_byte     = 1'b1;
                            phase_next    = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    area_byte        = 1'b1;
                    sum_next         = sum_add;
                    area_length_next = {b, 3'b000};
                    phase_next       = PH_LANG;
                end
                PH_LANG:
                begin
                    area_byte = 1'b1;
                    sum_next  = sum_add;
                    if (past_end)
                    begin
                        finished_next = 1'b1;
                        result.kind   = KIND_FINAL;
                        result.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        field_number_next = '0;
                        phase_next        = PH_TL;
                    end
                end
                PH_TL:
                begin
                    area_byte = 1'b1;
                    sum_next  = sum_add;
                    if (past_end)
                    begin
                        finished_next = 1'b1;
                        result.kind   = KIND_FINAL;
                        result.status = ST_OVERFLOW;
                    end
                    else if (field_number_reg >= FIXED_FIELDS && b == END_MARKER)
                        phase_next = PH_PAD;
                    else
                    begin
                        field_kind_next = tl_type;
                        remaining_next  = tl_length;
                        if (tl_type == TYPE_BCD || tl_type == TYPE_SIXBIT)
                        begin
                            finished_next = 1'b1;
                            result.kind   = KIND_FINAL;
                            result.status = ST_TYPE;
                        end
                        else
                        begin
                            if (tl_type == TYPE_BINARY || tl_length == 6'd0)
                            begin
                                result.kind        = KIND_EMPTY;
                                result.field_index = field_number_reg;
                            end
                            if (tl_length == 6'd0)
                                field_number_next = field_number_inc;
                            else
                                phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    area_byte = 1'b1;
                    sum_next  = sum_add;
                    if (past_end)
                    begin
                        finished_next = 1'b1;
                        result.kind   = KIND_FINAL;
                        result.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        if (field_kind_reg == TYPE_TEXT)
                        begin
                            result.kind        = KIND_CHAR;
                            result.field_index = field_number_reg;
                            result.char_value  = b;
                            result.field_last  = (remaining_reg == 6'd1);
                        end
                        remaining_next = remaining_reg - 6'd1;
                        if (remaining_reg == 6'd1)
                        begin
                            field_number_next = field_number_inc;
                            phase_next        = PH_TL;
                        end
                    end
                end
                PH_PAD:
                begin
                    area_byte = 1'b1;
                    sum_next  = sum_add;
                    if (past_end)
                    begin
                        finished_next = 1'b1;
                        result.kind   = KIND_FINAL;
                        result.status = (sum_add == 8'd0) ? ST_OK : ST_CHECKSUM;
                    end
                end
                default:
                begin
                    finished_next = 1'b1;
                    result.kind   = KIND_FINAL;
                    result.status = ST_HEADER;
                end
            endcase
        end

        area_pos_next  = area_byte ? area_pos_base + 11'd1 : area_pos_base;
        image_pos_next = (image_pos_reg != POS_MAX) ?
                         image_pos_reg + POSITION_BITS'(1) : image_pos_reg;

        // Last image byte: flag truncation, then rearm for a new image
        if (step_data.image_end)
        begin
            if (!finished_reg && result.kind != KIND_FINAL)
            begin
                result        = '0;
                result.kind   = KIND_FINAL;
                result.status = ST_TRUNCATED;
            end
            phase_next        = PH_HEADER;
            image_pos_next    = '0;
            area_offset_next  = '0;
            area_length_next  = '0;
            area_pos_next     = '0;
            sum_next          = '0;
            remaining_next    = '0;
            field_kind_next   = '0;
            field_number_next = '0;
            finished_next     = 1'b0;
        end
    end

    // Advance the parser state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            image_pos_reg    <= '0;
            area_offset_reg  <= '0;
            area_length_reg  <= '0;
            area_pos_reg     <= '0;
            sum_reg          <= '0;
            remaining_reg    <= '0;
            field_kind_reg   <= '0;
            field_number_reg <= '0;
            finished_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            image_pos_reg    <= image_pos_next;
            area_offset_reg  <= area_offset_next;
            area_length_reg  <= area_length_next;
            area_pos_reg     <= area_pos_next;
            sum_reg          <= sum_next;
            remaining_reg    <= remaining_next;
            field_kind_reg   <= field_kind_next;
            field_number_reg <= field_number_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

// ----- src/fru_product_info_parser_top.sv -----
// Top level of the FRU product info area parser: input and result registers.
//
// Usage: stream a FRU EEPROM image into the byte channel (byte_valid,
// byte_ready, byte_data), one byte per transfer, in address order from zero,
// with image_end set on the last byte. Every byte gives exactly one result
// transfer on the result channel (result_valid, result_ready, result_data):
// kind 0 for nothing, 1 for a text character, 2 for an empty field, 3 for the
// final status. After a final status the rest of the image gives kind 0.
// Path: a byte in the input register is decoded into the result register once
// that register is free. Throughput: one byte per cycle while result_ready is
// high, set by the single input and result registers around the decode logic.
// Reset: all parser state returns to the header start, both registers empty.
// A byte with image_end set also rearms the parser for a new image.
// Stall: when result_ready is low the result holds; an empty input register
// still takes one more byte, then byte_ready drops until the result moves on.
module fru_product_info_parser_top
    import fpi_pkg::*;
#(
    parameter int POSITION_BITS = PositionBitsDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  fpi_in_t  byte_data,
    output logic     result_valid,
    input  logic     result_ready,
    output fpi_out_t result_data
);

    logic     in_valid_reg;
    fpi_in_t  in_data_reg;
    logic     out_valid_reg;
    fpi_out_t out_data_reg;
    logic     out_free;
    logic     step;
    fpi_out_t step_result;

    // Move the held byte forward when the result register can take it
    assign out_free   = !out_valid_reg || result_ready;
    assign step       = in_valid_reg && out_free;
    assign byte_ready = !in_valid_reg || step;

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    fpi_parse_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .step_data (in_data_reg),
        .result    (step_result)
    );

    // Hold the input byte until it is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ready)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_data_reg <= byte_data;
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= step_result;
    end

endmodule

// ----- tb/sv/fru_parse_checker.sv -----
// Result checker for the FRU product info parser: byte-level predictor and scoreboard.
module fru_parse_checker
    import fpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  fpi_in_t     byte_data,
    input  logic        result_valid,
    input  logic        result_ready,
    input  fpi_out_t    result_data,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned char_count,
    output int unsigned empty_count,
    output logic [7:0]  status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W = PositionBitsDefault;

    // Parser state as the predictor tracks it
    phase_t           phase;
    logic [POS_W-1:0] image_pos;
    logic [7:0]       area_offset;
    logic [10:0]      area_length;
    logic [10:0]      area_pos;
    logic [7:0]       running_sum;
    logic [5:0]       field_remaining;
    logic [1:0]       field_kind;
    logic [3:0]       field_number;
    logic             finished;

    fpi_out_t predicted_results[$];
    fpi_out_t oldest;

    function automatic void clear_parser();
        phase           = PH_HEADER;
        image_pos       = '0;
        area_offset     = '0;
        area_length     = '0;
        area_pos        = '0;
        running_sum     = '0;
        field_remaining = '0;
        field_kind      = '0;
        field_number    = '0;
        finished        = 1'b0;
    endfunction

    // Build a final status result and stop parsing the image
    function automatic fpi_out_t close_with(logic [2:0] code);
        fpi_out_t res;
        res        = '0;
        res.kind   = KIND_FINAL;
        res.status = code;
        finished   = 1'b1;
        return res;
    endfunction

    function automatic void advance_field();
        if (field_number < FIELD_INDEX_MAX)
            field_number = field_number + 4'd1;
        phase = PH_TL;
    endfunction

    // True when the current area byte sits at or past the checksum slot
    function automatic bit beyond_area();
        return int'(area_pos) + 1 >= int'(area_length);
    endfunction

    // Advance the parser by one image byte and return the result it gives
    function automatic fpi_out_t parse_byte(fpi_in_t item);
        fpi_out_t   res;
        logic [7:0] b;
        logic       was_done;
        logic       area_step;
        res       = '0;
        b         = item.data_byte;
        was_done  = finished;
        area_step = 1'b0;

        if (!was_done) begin
            case (phase)
                PH_HEADER: begin
                    running_sum = running_sum + b;
                    if (image_pos == 0 && b != FORMAT_VERSION) begin
                        res = close_with(ST_HEADER);
                    end
                    else begin
                        if (image_pos == HdrOffsetAddr)
                            area_offset = b;
                        if (image_pos == HdrPadAddr && b != HDR_PAD_VALUE)
                            res = close_with(ST_HEADER);
                        else if (image_pos == HdrLastAddr) begin
                            if (running_sum != 8'h00)
                                res = close_with(ST_HEADER);
                            else if (area_offset == 8'h00)
                                res = close_with(ST_NO_AREA);
                            else
                                phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (image_pos == {area_offset, 3'b000}) begin
                        if (b != FORMAT_VERSION) begin
                            res = close_with(ST_AREA_VER);
                        end
                        else begin
                            running_sum = b;
                            area_pos    = '0;
                            area_step   = 1'b1;
                            phase       = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    area_step   = 1'b1;
                    running_sum = running_sum + b;
                    area_length = {b, 3'b000};
                    phase       = PH_LANG;
                end
                PH_LANG: begin
                    area_step   = 1'b1;
                    running_sum = running_sum + b;
                    if (beyond_area()) begin
                        res = close_with(ST_OVERFLOW);
                    end
                    else begin
                        field_number = '0;
                        phase        = PH_TL;
                    end
                end
                PH_TL: begin
                    area_step   = 1'b1;
                    running_sum = running_sum + b;
                    if (beyond_area()) begin
                        res = close_with(ST_OVERFLOW);
                    end
                    else if (field_number >= FIXED_FIELDS && b == END_MARKER) begin
                        phase = PH_PAD;
                    end
                    else begin
                        field_kind      = b[7:6];
                        field_remaining = b[5:0];
                        if (field_kind == TYPE_BCD || field_kind == TYPE_SIXBIT) begin
                            res = close_with(ST_TYPE);
                        end
                        else begin
                            if (field_kind == TYPE_BINARY || field_remaining == 0) begin
                                res.kind        = KIND_EMPTY;
                                res.field_index = field_number;
                            end
                            if (field_remaining == 0)
                                advance_field();
                            else
                                phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    area_step   = 1'b1;
                    running_sum = running_sum + b;
                    if (beyond_area()) begin
                        res = close_with(ST_OVERFLOW);
                    end
                    else begin
                        if (field_kind == TYPE_TEXT) begin
                            res.kind        = KIND_CHAR;
                            res.field_index = field_number;
                            res.char_value  = b;
                            res.field_last  = (field_remaining == 6'd1);
                        end
                        field_remaining = field_remaining - 6'd1;
                        if (field_remaining == 0)
                            advance_field();
                    end
                end
                PH_PAD: begin
                    area_step   = 1'b1;
                    running_sum = running_sum + b;
                    if (beyond_area())
                        res = close_with(running_sum == 8'h00 ? ST_OK : ST_CHECKSUM);
                end
                default: begin
                    res = close_with(ST_HEADER);
                end
            endcase
        end

        // Advance the counters; the image address saturates
        if (area_step)
            area_pos = area_pos + 11'd1;
        if (image_pos != {POS_W{1'b1}})
            image_pos = image_pos + 1'b1;

        // Last byte of an image: flag truncation, then rearm
        if (item.image_end) begin
            if (!was_done && res.kind != KIND_FINAL)
                res = close_with(ST_TRUNCATED);
            clear_parser();
        end
        return res;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Predict on each byte transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_parser();
            predicted_results.delete();
            fail_count  = 0;
            char_count  = 0;
            empty_count = 0;
            status_seen = '0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, result_data);
                    fail_count++;
                end
                else begin
                    oldest = predicted_results.pop_front();
                    compare_field("kind", oldest.kind, result_data.kind);
                    compare_field("field_index", oldest.field_index, result_data.field_index);
                    compare_field("char_value", oldest.char_value, result_data.char_value);
                    compare_field("field_last", oldest.field_last, result_data.field_last);
                    compare_field("status", oldest.status, result_data.status);
                    if (oldest.kind == KIND_CHAR)
                        char_count++;
                    if (oldest.kind == KIND_EMPTY)
                        empty_count++;
                    if (oldest.kind == KIND_FINAL)
                        status_seen[oldest.status] = 1'b1;
                end
            end
            if (byte_valid && byte_ready)
                predicted_results.push_back(parse_byte(byte_data));
        end
        pending = predicted_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top for the FRU product info parser: image stimulus, handshakes and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fpi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    fpi_in_t     byte_data;
    logic        result_valid;
    logic        result_ready = 1'b0;
    fpi_out_t    result_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned char_count;
    int unsigned empty_count;
    logic [7:0]  status_seen;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          bytes_sent  = 0;
    int          images_sent = 0;
    int          cycle_count = 0;

    // Image under construction, its area start and its type/length byte positions
    logic [7:0]  image[$];
    int          area_start;
    int          tl_at[$];

    fru_product_info_parser_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    fru_parse_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .char_count   (char_count),
        .empty_count  (empty_count),
        .status_seen  (status_seen)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side at the current rate
    always @(posedge clk)
        result_ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Header with random spare bytes, fixed checksum, then filler up to offset*8
    function automatic void begin_image(int offset);
        logic [7:0] sum;
        int         i;
        image.delete();
        tl_at.delete();
        image.push_back(FORMAT_VERSION);
        for (i = 1; i < 4; i++)
            image.push_back($urandom_range(0, 255));
        image.push_back(offset[7:0]);
        image.push_back($urandom_range(0, 255));
        image.push_back(HDR_PAD_VALUE);
        sum = 8'h00;
        for (i = 0; i < 7; i++)
            sum = sum + image[i];
        image.push_back(8'h00 - sum);
        for (i = 8; i < offset * 8; i++)
            image.push_back($urandom_range(0, 255));
    endfunction

    function automatic void open_area();
        area_start = image.size();
        image.push_back(FORMAT_VERSION);
        image.push_back(8'h00);
        image.push_back($urandom_range(0, 255));
    endfunction

    function automatic void add_field(logic [1:0] ftype, logic [5:0] len);
        tl_at.push_back(image.size());
        image.push_back({ftype, len});
        repeat (len)
            image.push_back($urandom_range(0, 255));
    endfunction

    function automatic void add_random_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            add_field(TYPE_TEXT, $urandom_range(0, 6));
        else if (r < 70)
            add_field(TYPE_TEXT, $urandom_range(7, 63));
        else if (r < 90)
            add_field(TYPE_BINARY, $urandom_range(0, 5));
        else
            add_field(TYPE_TEXT, 0);
    endfunction

    // End marker, padding to at least min_groups blocks of eight, then the checksum
    function automatic void close_area(int min_groups);
        int         groups;
        int         i;
        logic [7:0] sum;
        image.push_back(END_MARKER);
        groups = (image.size() - area_start + 8) / 8;
        if (groups < min_groups)
            groups = min_groups;
        while (image.size() - area_start < groups * 8 - 1)
            image.push_back($urandom_range(0, 255));
        image[area_start + 1] = groups[7:0];
        sum = 8'h00;
        for (i = area_start; i < image.size(); i++)
            sum = sum + image[i];
        image.push_back(8'h00 - sum);
    endfunction

    function automatic void good_image(int offset, int customs);
        begin_image(offset);
        open_area();
        repeat (7 + customs)
            add_random_field();
        close_area(1);
    endfunction

    function automatic void cut_to(int n);
        while (image.size() > n)
            image.delete(image.size() - 1);
    endfunction

    // Break a well-formed image in one of several ways
    function automatic void spoil_image();
        int         idx;
        logic [7:0] tl;
        logic [1:0] bad_type;
        case ($urandom_range(0, 7))
            0: begin
                idx = $urandom_range(0, image.size() - 1);
                image[idx] = image[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            1: cut_to($urandom_range(1, image.size() - 1));
            2: begin
                idx      = tl_at[$urandom_range(0, tl_at.size() - 1)];
                tl       = image[idx];
                bad_type = $urandom_range(0, 1) ? TYPE_BCD : TYPE_SIXBIT;
                image[idx] = {bad_type, tl[5:0]};
            end
            3: image[image.size() - 1] = image[image.size() - 1] + $urandom_range(1, 255);
            4: begin
                tl = image[area_start + 1];
                image[area_start + 1] = $urandom_range(0, tl - 1);
            end
            5: begin
                repeat ($urandom_range(1, 10))
                    image.push_back($urandom_range(0, 255));
            end
            6: image[area_start] = image[area_start] ^ $urandom_range(1, 255);
            default: image[HdrPadAddr] = $urandom_range(1, 255);
        endcase
    endfunction

    function automatic void random_image();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            // Noise: short run of random bytes, sometimes with a valid version
            image.delete();
            repeat ($urandom_range(1, 16))
                image.push_back($urandom_range(0, 255));
            if ($urandom_range(0, 1))
                image[0] = FORMAT_VERSION;
        end
        else if (r < 9) begin
            begin_image(0);
            repeat ($urandom_range(0, 8))
                image.push_back($urandom_range(0, 255));
        end
        else begin
            good_image(r < 20 ? $urandom_range(2, 3) : 1,
                       $urandom_range(0, 19) == 0 ? $urandom_range(8, 12) : $urandom_range(0, 3));
            if ($urandom_range(0, 99) < 35)
                spoil_image();
        end
    endfunction

    // Hold valid until the transfer, then maybe idle for a while
    task automatic send_byte(logic [7:0] value, logic last);
        byte_valid <= 1'b1;
        byte_data  <= {value, last};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            byte_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic send_image();
        int i;
        for (i = 0; i < image.size(); i++)
            send_byte(image[i], i == image.size() - 1);
        images_sent++;
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain();
        byte_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic run_directed();
        // Minimal good area: seven empty text fields
        begin_image(1);
        open_area();
        repeat (7)
            add_field(TYPE_TEXT, 0);
        close_area(1);
        send_image();

        // Mixed fields, end marker as a fixed field, extreme chars, index saturation
        begin_image(2);
        open_area();
        add_field(TYPE_TEXT, 3);
        add_field(TYPE_BINARY, 2);
        add_field(TYPE_BINARY, 0);
        add_field(TYPE_TEXT, 63);
        add_field(TYPE_TEXT, 1);
        add_field(TYPE_TEXT, 2);
        image[image.size() - 2] = 8'h00;
        image[image.size() - 1] = 8'hFF;
        add_field(TYPE_TEXT, 2);
        repeat (10)
            add_field(TYPE_TEXT, 2);
        close_area(1);
        send_image();

        // Header failures: version, pad, checksum
        good_image(1, 0);
        image[0] = 8'h00;
        cut_to(12);
        send_image();
        good_image(1, 0);
        image[HdrPadAddr] = 8'hFF;
        cut_to(12);
        send_image();
        good_image(1, 0);
        image[HdrLastAddr] = image[HdrLastAddr] + 8'd1;
        cut_to(12);
        send_image();

        // Zero offset with trailing bytes
        begin_image(0);
        repeat (8)
            image.push_back($urandom_range(0, 255));
        send_image();

        // Bad area version
        good_image(1, 0);
        image[area_start] = 8'h02;
        cut_to(12);
        send_image();

        // BCD and six-bit field types
        good_image(1, 0);
        image[tl_at[0]] = {TYPE_BCD, 6'd2};
        cut_to(tl_at[0] + 2);
        send_image();
        good_image(1, 1);
        image[tl_at[3]] = {TYPE_SIXBIT, 6'd5};
        cut_to(tl_at[3] + 2);
        send_image();

        // Bad area checksum
        good_image(1, 2);
        image[image.size() - 1] = image[image.size() - 1] ^ 8'h01;
        send_image();

        // Overflow: zero area length, then an area too short for its fields
        good_image(1, 0);
        image[area_start + 1] = 8'h00;
        cut_to(14);
        send_image();
        good_image(1, 3);
        image[area_start + 1] = 8'h01;
        cut_to(20);
        send_image();

        // Truncation inside the header and on a text character
        good_image(1, 0);
        cut_to(3);
        send_image();
        begin_image(1);
        open_area();
        add_field(TYPE_TEXT, 4);
        repeat (6)
            add_field(TYPE_TEXT, 0);
        close_area(1);
        cut_to(tl_at[0] + 3);
        send_image();

        // One-byte image
        image.delete();
        image.push_back(FORMAT_VERSION);
        send_image();

        // Bytes after a good status
        good_image(1, 1);
        repeat (5)
            image.push_back($urandom_range(0, 255));
        send_image();
    endtask

    task automatic random_phase(int idle, int stall, int quota);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = bytes_sent;
        while (bytes_sent - start < quota) begin
            random_image();
            send_image();
        end
        drain();
    endtask

    initial begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_data  = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        random_phase(0, 0, 40);
        random_phase(83, 0, 40);
        random_phase(0, 83, 40);
        random_phase(30, 30, 40);

        // Let any stray result surface
        repeat (8)
            @(posedge clk);

        $display("Sent %0d bytes in %0d images, directed cases then four idle/stall mixes.",
                 bytes_sent, images_sent);
        $display("Saw %0d text characters, %0d empty fields, final status set %b.",
                 char_count, empty_count, status_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
